// File: rtl/sca_pkg.sv
package sca_pkg;

   localparam int COST_WIDTH_DEF = 24;
   localparam int STEP_WIDTH_DEF = 32;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int LIMIT_WIDTH   = 16;
   localparam int MODE_WIDTH    = 3;
   localparam int MIN_IDLE_WIDTH = 32;
   localparam int FRAC_WIDTH    = 16;
   localparam int SCOUNT_WIDTH  = 17;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNTER_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_MODE     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_IDLE_STEPS = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDLE_FRACTION  = 2'd3;

   localparam logic [LIMIT_WIDTH-1:0]    COUNTER_LIMIT_RST  = 16'd1000;
   localparam logic [MODE_WIDTH-1:0]     COUNT_MODE_RST     = 3'd1;
   localparam logic [MIN_IDLE_WIDTH-1:0] MIN_IDLE_STEPS_RST = 32'd10000;
   localparam logic [FRAC_WIDTH-1:0]     IDLE_FRACTION_RST  = 16'd10;

   localparam logic OP_START     = 1'b0;
   localparam logic OP_CANDIDATE = 1'b1;

   localparam int MODE_EVERY    = 0;
   localparam int MODE_ACCEPTED = 1;
   localparam int MODE_IMPROVED = 2;

   typedef struct packed {
      logic load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// File: rtl/sca_ctrl.sv
module sca_ctrl
   import sca_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/sca_dp.sv
module sca_dp
   import sca_pkg::*;
#(
   parameter int COST_WIDTH = COST_WIDTH_DEF,
   parameter int STEP_WIDTH = STEP_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                       req_op,
   input  logic [COST_WIDTH-1:0]      req_cost,
   input  cmd_type                    cmd,
   output status_type                 status,
   output logic                       rsp_accepted,
   output logic                       rsp_improved,
   output logic                       rsp_bound_refreshed,
   output logic [COST_WIDTH-1:0]      rsp_current_cost_out,
   output logic [COST_WIDTH-1:0]      rsp_cost_bound_out,
   output logic                       rsp_keep_running
);

   localparam int CNT_WIDTH = (STEP_WIDTH > 1) ? $clog2(STEP_WIDTH) : 1;
   localparam int CMP_WIDTH = (STEP_WIDTH > MIN_IDLE_WIDTH) ? STEP_WIDTH : MIN_IDLE_WIDTH;

   // configuration
   logic [LIMIT_WIDTH-1:0]    limit_ff;
   logic [MODE_WIDTH-1:0]     mode_ff;
   logic [MIN_IDLE_WIDTH-1:0] min_idle_ff;
   logic [FRAC_WIDTH-1:0]     frac_ff;

   // search state
   logic [COST_WIDTH-1:0]   cur_ff, cur_in;
   logic [COST_WIDTH-1:0]   bound_ff, bound_in;
   logic [SCOUNT_WIDTH-1:0] scount_ff, scount_in;
   logic [STEP_WIDTH-1:0]   idle_ff, idle_in;
   logic [STEP_WIDTH-1:0]   total_ff, total_in;
   logic                    acc_ff, acc_in;
   logic                    imp_ff, imp_in;
   logic                    refr_ff, refr_in;

   // serial divider
   logic [FRAC_WIDTH-1:0] rem_ff;
   logic [STEP_WIDTH-1:0] quo_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;
   logic [FRAC_WIDTH:0]   rem_shift;
   logic                  quo_bit;

   logic [SCOUNT_WIDTH+1:0] scount_sum;
   logic [1:0]              incr_a;
   logic                    keep_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= COUNTER_LIMIT_RST;
         mode_ff     <= COUNT_MODE_RST;
         min_idle_ff <= MIN_IDLE_STEPS_RST;
         frac_ff     <= IDLE_FRACTION_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COUNTER_LIMIT:  limit_ff    <= csr_data[LIMIT_WIDTH-1:0];
            CSR_COUNT_MODE:     mode_ff     <= csr_data[MODE_WIDTH-1:0];
            CSR_MIN_IDLE_STEPS: min_idle_ff <= csr_data[MIN_IDLE_WIDTH-1:0];
            CSR_IDLE_FRACTION:  frac_ff     <= csr_data[FRAC_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cur_in    = cur_ff;
      bound_in  = bound_ff;
      scount_in = '0;
      idle_in   = '0;
      total_in  = '0;
      acc_in    = 1'b0;
      imp_in    = 1'b0;
      refr_in   = 1'b0;
      incr_a    = '0;
      scount_sum = '0;
      if (req_op == OP_START) begin
         cur_in   = req_cost;
         bound_in = req_cost;
      end else begin
         acc_in  = (req_cost < bound_ff) || (req_cost <= cur_ff);
         imp_in  = (req_cost < cur_ff);
         idle_in = imp_in ? '0 : ((idle_ff == '1) ? idle_ff : idle_ff + 1'b1);
         if (acc_in) begin
            cur_in = req_cost;
         end
         incr_a = {1'b0, imp_in && mode_ff[MODE_IMPROVED]}
                + {1'b0, acc_in && mode_ff[MODE_ACCEPTED]}
                + {1'b0, mode_ff[MODE_EVERY]};
         scount_sum = {2'b00, scount_ff} + {{SCOUNT_WIDTH{1'b0}}, incr_a};
         scount_in  = (scount_sum[SCOUNT_WIDTH+1:SCOUNT_WIDTH] != 2'b00) ? '1
                    : scount_sum[SCOUNT_WIDTH-1:0];
         if (scount_in >= {1'b0, limit_ff}) begin
            bound_in  = cur_in;
            scount_in = '0;
            refr_in   = 1'b1;
         end
         total_in = (total_ff == '1) ? total_ff : total_ff + 1'b1;
      end
   end

   assign rem_shift = {rem_ff, quo_ff[STEP_WIDTH-1]};
   assign quo_bit   = (rem_shift >= {1'b0, frac_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff    <= '0;
         bound_ff  <= '0;
         scount_ff <= '0;
         idle_ff   <= '0;
         total_ff  <= '0;
      end else if (cmd.load) begin
         cur_ff    <= cur_in;
         bound_ff  <= bound_in;
         scount_ff <= scount_in;
         idle_ff   <= idle_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff  <= acc_in;
         imp_ff  <= imp_in;
         refr_ff <= refr_in;
         rem_ff  <= '0;
         quo_ff  <= total_in;
         cnt_ff  <= CNT_WIDTH'(STEP_WIDTH - 1);
      end else if (cmd.div_step) begin
         rem_ff <= quo_bit ? FRAC_WIDTH'(rem_shift - {1'b0, frac_ff})
                           : rem_shift[FRAC_WIDTH-1:0];
         quo_ff <= {quo_ff[STEP_WIDTH-2:0], quo_bit};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign status.div_last = (cnt_ff == '0);

   assign keep_run = (CMP_WIDTH'(idle_ff) <= CMP_WIDTH'(min_idle_ff))
                  || (idle_ff <= quo_ff);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_accepted         <= acc_ff;
         rsp_improved         <= imp_ff;
         rsp_bound_refreshed  <= refr_ff;
         rsp_current_cost_out <= cur_ff;
         rsp_cost_bound_out   <= bound_ff;
         rsp_keep_running     <= keep_run;
      end
   end

endmodule

// File: rtl/step_counting_acceptance.sv
// Acceptance unit for step counting hill climbing.
// Requests arrive on req_valid/req_ready with req_op and req_cost. A start
// request loads the cost into the current cost and the bound and clears the
// counters; a candidate request is judged against the current cost and bound.
// Each request yields exactly one response on rsp_valid/rsp_ready with the
// acceptance flags, the updated costs and the keep_running flag.
// Timing: a request is taken in the idle state, then the convergence test
// runs a restoring divide of total steps by idle_fraction, one quotient bit
// per cycle; the result is then registered when the output register is free.
// The response sits in an output register, so the next request is taken while
// the receiver stalls; its result waits in the datapath until the register frees.
// Reset restores the register defaults and clears costs and counters.
// csr_write/csr_index/csr_data write a register; the user must do so only while idle, the block does not enforce it.
module step_counting_acceptance
   import sca_pkg::*;
#(
   parameter int COST_WIDTH = COST_WIDTH_DEF,
   parameter int STEP_WIDTH = STEP_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [COST_WIDTH-1:0]      req_cost,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_accepted,
   output logic                       rsp_improved,
   output logic                       rsp_bound_refreshed,
   output logic [COST_WIDTH-1:0]      rsp_current_cost_out,
   output logic [COST_WIDTH-1:0]      rsp_cost_bound_out,
   output logic                       rsp_keep_running
);

   cmd_type    cmd;
   status_type status;

   sca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sca_dp #(
      .COST_WIDTH (COST_WIDTH),
      .STEP_WIDTH (STEP_WIDTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_op               (req_op),
      .req_cost             (req_cost),
      .cmd                  (cmd),
      .status               (status),
      .rsp_accepted         (rsp_accepted),
      .rsp_improved         (rsp_improved),
      .rsp_bound_refreshed  (rsp_bound_refreshed),
      .rsp_current_cost_out (rsp_current_cost_out),
      .rsp_cost_bound_out   (rsp_cost_bound_out),
      .rsp_keep_running     (rsp_keep_running)
   );

endmodule
